>>> rtl/core/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the LZ77 token decoder: token commands,
// result packing width and the request and response beat layouts.
// ----------------------------------------------------------------------------
package lzd_pkg;

   // token commands
   localparam logic [1:0] CMD_LITERAL = 2'd0;
   localparam logic [1:0] CMD_COPY    = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;

   // byte fields carried by one response beat
   localparam int RESULT_BYTES = 4;

   localparam int DEFAULT_WINDOW_DEPTH = 65536;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  literal_byte;
      logic [15:0] distance;
      logic [7:0]  copy_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte_zero;
      logic [7:0] out_byte_one;
      logic [7:0] out_byte_two;
      logic [7:0] out_byte_three;
      logic [2:0] byte_count;
      logic       last_of_token;
      logic       bad_distance;
   } rsp_type;

endpackage

>>> rtl/core/lz77_token_decoder.sv
// ----------------------------------------------------------------------------
// lz77_token_decoder
// Decodes literal and back-reference tokens into bytes over a history ring
// held in one synchronous single-write memory.
// ----------------------------------------------------------------------------
// Response: a literal or an error token gives a registered beat that shows in
//   the next cycle; a start-stream token gives none. A copy holds the request
//   side until its last byte is written back, one history byte per cycle
//   through the memory's read-then-write loop, unless the response side stalls.
// Reset: clears the sequencer, write position and byte count; the history
//   memory is not cleared, no clearing pass runs.
// ----------------------------------------------------------------------------
module lz77_token_decoder #(
   parameter int WINDOW_DEPTH = lzd_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lzd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lzd_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int BW = $clog2(WINDOW_DEPTH + 1);
   localparam int CW = $clog2(lzd_pkg::RESULT_BYTES);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_COPY = 1'b1;

   // history ring
   logic [7:0] hist_mem [0:WINDOW_DEPTH-1];
   logic [7:0] rdata_ff;

   logic          state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [BW-1:0] bw_ff, bw_in;
   logic [AW-1:0] src_ff, src_in;
   logic          dist1_ff, dist1_in;
   logic [7:0]    issue_left_ff, issue_left_in;
   logic          d_valid_ff, d_valid_in;
   logic          d_last_ff, d_last_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]    pack_ff [0:lzd_pkg::RESULT_BYTES-2];
   logic [7:0]    pack_in [0:lzd_pkg::RESULT_BYTES-2];
   logic [7:0]    prev_ff, prev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   lzd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;

   logic          out_free;
   logic          req_take;
   logic          bad;
   logic [16:0]   dist_ext;
   logic [16:0]   bw_ext;
   logic [16:0]   wp_ext;
   logic [16:0]   src_full;
   logic [AW-1:0] wp_step;
   logic [AW-1:0] src_step;
   logic [BW-1:0] bw_step;
   logic [7:0]    d_byte;
   logic          d_push;
   logic          d_consume;
   logic          issue;
   logic [7:0]    beat_bytes [0:lzd_pkg::RESULT_BYTES-1];

   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // response register frees up when empty or drained this cycle
      out_free = !rsp_valid_ff || !rsp_stall;
      req_take = req_valid && !req_stall;

      // distance check against bytes written in this stream
      dist_ext = 17'(req_data.distance);
      bw_ext   = 17'(bw_ff);
      wp_ext   = 17'(wp_ff);
      bad      = (req_data.distance == 16'd0) || (dist_ext > bw_ext);

      // copy source start, wrapped into the ring
      if (wp_ext >= dist_ext) begin
         src_full = wp_ext - dist_ext;
      end else begin
         src_full = wp_ext + 17'(WINDOW_DEPTH) - dist_ext;
      end

      wp_step  = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      src_step = (src_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : src_ff + 1'b1;
      bw_step  = (bw_ff == BW'(WINDOW_DEPTH)) ? bw_ff : bw_ff + 1'b1;

      // distance one repeats the byte just written; the memory would
      // return the stale entry in that case
      d_byte    = dist1_ff ? prev_ff : rdata_ff;
      d_push    = d_valid_ff
                  && ((cnt_ff == CW'(lzd_pkg::RESULT_BYTES - 1)) || d_last_ff);
      d_consume = d_valid_ff && (!d_push || out_free);
      issue     = (state_ff == ST_COPY) && (issue_left_ff != 8'd0)
                  && (!d_valid_ff || d_consume);

      // hold by default
      state_in      = state_ff;
      wp_in         = wp_ff;
      bw_in         = bw_ff;
      src_in        = src_ff;
      dist1_in      = dist1_ff;
      issue_left_in = issue_left_ff;
      d_last_in     = d_last_ff;
      cnt_in        = cnt_ff;
      pack_in       = pack_ff;
      prev_in       = prev_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_waddr     = wp_ff;
      mem_wdata     = d_byte;
      mem_re        = issue;

      // assemble the outgoing copy beat: earlier bytes, this byte, zero fill
      for (int j = 0; j < lzd_pkg::RESULT_BYTES; j++) begin
         if (j < int'(cnt_ff)) begin
            beat_bytes[j] = pack_ff[j];
         end else if (j == int'(cnt_ff)) begin
            beat_bytes[j] = d_byte;
         end else begin
            beat_bytes[j] = 8'd0;
         end
      end

      // advance the data stage
      if (issue) begin
         d_valid_in = 1'b1;
      end else if (d_consume) begin
         d_valid_in = 1'b0;
      end else begin
         d_valid_in = d_valid_ff;
      end

      if (req_take) begin
         case (req_data.command)
            lzd_pkg::CMD_LITERAL: begin
               mem_we       = 1'b1;
               mem_wdata    = req_data.literal_byte;
               wp_in        = wp_step;
               bw_in        = bw_step;
               prev_in      = req_data.literal_byte;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte_zero:  req_data.literal_byte,
                                out_byte_one:   8'd0,
                                out_byte_two:   8'd0,
                                out_byte_three: 8'd0,
                                byte_count:     3'd1,
                                last_of_token:  1'b1,
                                bad_distance:   1'b0};
            end
            lzd_pkg::CMD_COPY: begin
               if (req_data.copy_length != 8'd0) begin
                  if (bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte_zero:  8'd0,
                                      out_byte_one:   8'd0,
                                      out_byte_two:   8'd0,
                                      out_byte_three: 8'd0,
                                      byte_count:     3'd0,
                                      last_of_token:  1'b1,
                                      bad_distance:   1'b1};
                  end else begin
                     state_in      = ST_COPY;
                     src_in        = src_full[AW-1:0];
                     dist1_in      = (req_data.distance == 16'd1);
                     issue_left_in = req_data.copy_length;
                     cnt_in        = '0;
                  end
               end
            end
            lzd_pkg::CMD_START: begin
               wp_in = '0;
               bw_in = '0;
            end
            default: begin
               // unused command: drop
            end
         endcase
      end

      // copy: launch the next source read
      if (issue) begin
         src_in        = src_step;
         issue_left_in = issue_left_ff - 8'd1;
         d_last_in     = (issue_left_ff == 8'd1);
      end

      // copy: write the byte back into history and pack it
      if (d_consume) begin
         mem_we  = 1'b1;
         wp_in   = wp_step;
         bw_in   = bw_step;
         prev_in = d_byte;
         if (d_push) begin
            cnt_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{out_byte_zero:  beat_bytes[0],
                             out_byte_one:   beat_bytes[1],
                             out_byte_two:   beat_bytes[2],
                             out_byte_three: beat_bytes[3],
                             byte_count:     3'(cnt_ff) + 3'd1,
                             last_of_token:  d_last_ff,
                             bad_distance:   1'b0};
         end else begin
            pack_in[cnt_ff] = d_byte;
            cnt_in          = cnt_ff + 1'b1;
         end
         if (d_last_ff) begin
            state_in = ST_IDLE;
         end
      end
   end

   // history memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= hist_mem[src_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wp_ff         <= '0;
         bw_ff         <= '0;
         issue_left_ff <= '0;
         d_valid_ff    <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         bw_ff         <= bw_in;
         issue_left_ff <= issue_left_in;
         d_valid_ff    <= d_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dist1_ff    <= dist1_in;
      d_last_ff   <= d_last_in;
      pack_ff     <= pack_in;
      prev_ff     <= prev_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sim/lz77_token_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_token_decoder_tb
// Self-checking bench for the LZ77 token decoder. A bit-exact decoder model
// runs beside the block and queues the beats each accepted token must produce.
// The bench also covers back-pressure, random token streams, and a
// history-ring wrap past the full window.
// ----------------------------------------------------------------------------
module lz77_token_decoder_tb;

   // command code with no meaning; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int HISTORY_DEPTH    = lzd_pkg::DEFAULT_WINDOW_DEPTH;
   localparam int MAX_REACH        = 65535;     // largest distance the field holds
   localparam int QUIET_LIMIT      = 4000;      // cycles with no beat moving
   localparam int DRAIN_CYCLES     = 16;
   localparam int HOLD_OFF_CYCLES  = 150;
   localparam int PRESSURE_TOKENS  = 16;
   localparam int RANDOM_TOKENS    = 16;
   localparam int WRAP_LITERALS    = 4;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   lzd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   lzd_pkg::rsp_type rsp_data;

   lz77_token_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------------
   // Decoder model state: history ring, next write slot, bytes in stream.
   // ------------------------------------------------------------------------
   logic [7:0]  history [0:HISTORY_DEPTH-1];
   logic [15:0] next_slot    = '0;
   int unsigned stream_bytes = 0;

   // beats still owed by the block, oldest first
   lzd_pkg::rsp_type decoded_q[$];

   int          error_count  = 0;
   int          quiet_cycles = 0;
   bit          idle_en      = 1'b1;   // random gaps on both channels
   int          hold_request = 0;      // receiver hold-off, in cycles

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------

   // Store one decoded byte in the ring; the count saturates at the window.
   function automatic void record_byte(input logic [7:0] b);
      history[next_slot] = b;
      next_slot          = next_slot + 16'd1;
      if (stream_bytes < HISTORY_DEPTH)
         stream_bytes++;
   endfunction

   // Advance the model by one accepted token and queue the beats it owes.
   function automatic void decode_token(input lzd_pkg::req_type tok);
      lzd_pkg::rsp_type beat;
      logic [7:0]       b;
      logic [15:0]      src;
      int               n;
      int               remaining;
      case (tok.command)
         lzd_pkg::CMD_LITERAL: begin
            record_byte(tok.literal_byte);
            beat               = '0;
            beat.out_byte_zero = tok.literal_byte;
            beat.byte_count    = 3'd1;
            beat.last_of_token = 1'b1;
            decoded_q.push_back(beat);
         end
         lzd_pkg::CMD_START: begin
            // forget the stream; the ring contents stay but are unreachable
            next_slot    = '0;
            stream_bytes = 0;
         end
         lzd_pkg::CMD_COPY: begin
            if (tok.copy_length != 8'd0) begin
               if (tok.distance == 16'd0 || tok.distance > stream_bytes) begin
                  // bad distance: one empty error beat, state untouched
                  beat               = '0;
                  beat.last_of_token = 1'b1;
                  beat.bad_distance  = 1'b1;
                  decoded_q.push_back(beat);
               end else begin
                  remaining = int'(tok.copy_length);
                  while (remaining > 0) begin
                     beat = '0;
                     n    = 0;
                     while (n < lzd_pkg::RESULT_BYTES && remaining > 0) begin
                        // read before write, so overlapping copies repeat
                        src = next_slot - tok.distance;
                        b   = history[src];
                        record_byte(b);
                        case (n)
                           0: beat.out_byte_zero  = b;
                           1: beat.out_byte_one   = b;
                           2: beat.out_byte_two   = b;
                           default: beat.out_byte_three = b;
                        endcase
                        n++;
                        remaining--;
                     end
                     beat.byte_count    = n[2:0];
                     beat.last_of_token = (remaining == 0);
                     decoded_q.push_back(beat);
                  end
               end
            end
         end
         default: ;   // unused command: no beat, no state change
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Token builders
   // ------------------------------------------------------------------------
   function automatic lzd_pkg::req_type token(input logic [1:0] cmd,
                                              input logic [7:0] lit,
                                              input logic [15:0] dist_field,
                                              input logic [7:0] len);
      lzd_pkg::req_type tok;
      tok.command      = cmd;
      tok.literal_byte = lit;
      tok.distance     = dist_field;
      tok.copy_length  = len;
      return tok;
   endfunction

   // Literal with junk in the fields the block should not look at.
   function automatic lzd_pkg::req_type random_literal();
      return token(lzd_pkg::CMD_LITERAL, 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
   endfunction

   // Mostly short copies, now and then a long one.
   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return $urandom_range(1, 12);
      else if (r < 19)
         return $urandom_range(13, 64);
      return $urandom_range(65, 255);
   endfunction

   // Copy that reaches only bytes of this stream; needs stream_bytes > 0.
   function automatic lzd_pkg::req_type good_copy(input int unsigned len);
      int unsigned reach;
      int unsigned back_dist;
      reach = (stream_bytes > MAX_REACH) ? MAX_REACH : stream_bytes;
      if ($urandom_range(0, 1) == 0)
         back_dist = $urandom_range(1, (reach < 8) ? reach : 8);
      else
         back_dist = $urandom_range(1, reach);
      return token(lzd_pkg::CMD_COPY, 8'($urandom_range(0, 255)), 16'(back_dist),
                   8'(len));
   endfunction

   // Copy whose distance is zero or beyond the bytes written.
   function automatic lzd_pkg::req_type bad_copy();
      int unsigned back_dist;
      if (stream_bytes >= MAX_REACH || $urandom_range(0, 3) == 0)
         back_dist = 0;
      else
         back_dist = $urandom_range(stream_bytes + 1, MAX_REACH);
      return token(lzd_pkg::CMD_COPY, 8'($urandom_range(0, 255)), 16'(back_dist),
                   8'($urandom_range(1, 255)));
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Enter and leave at a falling edge; valid stays high
   // between back-to-back tokens and the payload holds while stalled.
   // ------------------------------------------------------------------------
   task automatic push_token(input lzd_pkg::req_type tok);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = tok;
      do @(posedge clock); while (req_stall);
      decode_token(tok);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, plus a long hold-off on request.
   // ------------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            rsp_stall = 1'b1;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
            rsp_stall    = 1'b0;
         end else if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare every accepted beat against the oldest owed one.
   always @(posedge clock) begin
      lzd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            $display("%0t: beat with nothing owed, expected none got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("out_byte_zero",  want.out_byte_zero,  rsp_data.out_byte_zero);
            check_field("out_byte_one",   want.out_byte_one,   rsp_data.out_byte_one);
            check_field("out_byte_two",   want.out_byte_two,   rsp_data.out_byte_two);
            check_field("out_byte_three", want.out_byte_three, rsp_data.out_byte_three);
            check_field("byte_count",     8'(want.byte_count),
                        8'(rsp_data.byte_count));
            check_field("last_of_token",  8'(want.last_of_token),
                        8'(rsp_data.last_of_token));
            check_field("bad_distance",   8'(want.bad_distance),
                        8'(rsp_data.bad_distance));
         end
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes, every command and each corner of copy handling.
   task automatic test_directed();
      push_token(token(lzd_pkg::CMD_START, 8'h00, 16'h0000, 8'h00));
      // nothing written yet: any copy is out of reach
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd1, 8'd1));
      // zero-length copies produce nothing, whatever the distance
      push_token(token(lzd_pkg::CMD_COPY, 8'hFF, 16'h0000, 8'd0));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'hFFFF, 8'd0));
      push_token(token(lzd_pkg::CMD_LITERAL, 8'h00, 16'hFFFF, 8'hFF));
      push_token(token(lzd_pkg::CMD_LITERAL, 8'hFF, 16'h0000, 8'h00));
      push_token(token(lzd_pkg::CMD_LITERAL, 8'hA5, 16'h5555, 8'h55));
      push_token(token(lzd_pkg::CMD_LITERAL, 8'h5A, 16'hAAAA, 8'hAA));
      // zero distance and distances past the written bytes
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd0, 8'd255));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd5, 8'd3));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'hFFFF, 8'd128));
      // single byte, overlapping run, exact four-byte beat
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd1, 8'd1));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd1, 8'd9));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd4, 8'd4));
      // longest copy, at short range and from the very first byte
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd3, 8'd255));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, stream_bytes[15:0], 8'd255));
      // unused command must leave the stream as it was
      push_token(token(CMD_UNUSED, 8'hFF, 16'hFFFF, 8'hFF));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd2, 8'd2));
      // new stream forgets history even though the ring still holds it
      push_token(token(lzd_pkg::CMD_START, 8'hFF, 16'hFFFF, 8'hFF));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd1, 8'd4));
      push_token(token(lzd_pkg::CMD_LITERAL, 8'h3C, 16'h0000, 8'h00));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd1, 8'd5));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd7, 8'd1));
   endtask

   // Hold the receiver off while tokens keep coming, so the block fills and
   // stalls its request side; then let it drain.
   task automatic test_backpressure();
      int i;
      idle_en      = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      for (i = 0; i < PRESSURE_TOKENS; i++) begin
         if (i % 3 == 2 && stream_bytes != 0)
            push_token(good_copy($urandom_range(1, 8)));
         else
            push_token(random_literal());
      end
      idle_en = 1'b1;
   endtask

   // Mostly well-formed streams with random content, mixed with noise.
   task automatic test_random_stream(input int count);
      int done;
      int r;
      done = 0;
      while (done < count) begin
         // leave every third stretch of four tokens free of gaps
         idle_en = ((done / 4) % 3) != 2;
         r       = $urandom_range(0, 99);
         if (stream_bytes == 0 || r < 40) begin
            push_token(random_literal());
         end else if (r < 80) begin
            push_token(good_copy(pick_length()));
         end else if (r < 88) begin
            push_token(bad_copy());
         end else if (r < 92) begin
            // zero length: ignored, does not count
            push_token(token(lzd_pkg::CMD_COPY, 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), 8'd0));
            continue;
         end else if (r < 95) begin
            push_token(token(lzd_pkg::CMD_START, 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255))));
         end else if (r < 98) begin
            push_token(token(CMD_UNUSED, 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255))));
            continue;
         end else begin
            push_token(good_copy(255));
         end
         done++;
      end
   endtask

   // Write past the full window so the count saturates and the write slot
   // wraps, then copy from the farthest reachable distances.
   task automatic test_window_wrap();
      int i;
      idle_en = 1'b0;
      push_token(token(lzd_pkg::CMD_START, 8'h00, 16'h0000, 8'h00));
      for (i = 0; i < WRAP_LITERALS; i++)
         push_token(random_literal());
      while (stream_bytes < HISTORY_DEPTH)
         push_token(good_copy(255));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'hFFFF, 8'd255));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'hFFFE, 8'd255));
      push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'd0, 8'd1));
      push_token(random_literal());
      for (i = 0; i < 4; i++)
         push_token(token(lzd_pkg::CMD_COPY, 8'h00, 16'($urandom_range(32768, 65535)),
                          8'($urandom_range(1, 255))));
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random_stream(RANDOM_TOKENS);
      test_window_wrap();
      req_valid = 1'b0;

      // drain what is owed, then watch a little longer for stray beats
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
